// ===== design/sfn2d_pkg.sv =====
package sfn2d_pkg;

  // pipeline stages, in order from input to output
  localparam int NUM_STAGES = 7;
  localparam int STG_SETUP  = 0;
  localparam int STG_GRAD   = 1;
  localparam int STG_ROT    = 2;
  localparam int STG_DOT    = 3;
  localparam int STG_FALL   = 4;
  localparam int STG_TERM   = 5;
  localparam int STG_SUM    = 6;

  // gradient magnitudes
  localparam logic signed [7:0] GRAD_LO = 8'sd54;
  localparam logic signed [7:0] GRAD_HI = 8'sd108;

  // hash polynomial coefficients, reduced mod 8 since only three hash bits are used
  localparam logic [2:0] HASH_A = 3'd5;  // 13 mod 8
  localparam logic [2:0] HASH_B = 3'd7;
  localparam logic [2:0] HASH_C = 3'd7;  // 15 mod 8
  localparam logic [2:0] HASH_D = 3'd3;  // 11 mod 8

  // radial falloff
  localparam logic [7:0] FALLOFF_RADIUS = 8'd102;
  localparam logic [7:0] FALLOFF_ONE    = 8'd255;

  // output gain, 136/128
  localparam logic signed [17:0] OUT_GAIN = 18'sd136;

  // fake sine constants
  localparam logic signed [8:0] SIN_HALF = 9'sd128;
  localparam logic [7:0]        SIN_ONE  = 8'd127;
  localparam logic [7:0]        QUARTER  = 8'd64;

  // per-stage load enables
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

  // simplex corner, only the low three bits of each lattice coordinate matter
  typedef struct packed {
    logic [2:0] cu;
    logic [2:0] cv;
  } corner_t;

  // values shared by all three corners
  typedef struct packed {
    logic [7:0]        lx;
    logic [7:0]        ly;
    logic              rot;
    logic signed [7:0] ca;
    logic signed [7:0] sa;
  } shared_t;

  // parabolic fake sine, full turn is 256, result wraps to 8 bits
  function automatic logic signed [7:0] par_sin(input logic [7:0] a);
    logic signed [8:0]  t2;
    logic [8:0]         ab;
    logic signed [7:0]  q;
    logic signed [15:0] qq;
    logic [7:0]         qs;
    logic [7:0]         r;
    t2 = $signed({1'b0, a[6:0], 1'b0}) - SIN_HALF;
    ab = t2[8] ? 9'(-t2) : 9'(t2);
    q  = $signed(ab[7:0]);
    qq = q * q;
    qs = qq[14:7];
    r  = 8'(SIN_ONE - qs);
    return a[7] ? $signed(8'(-r)) : $signed(r);
  endfunction

  function automatic logic signed [7:0] par_cos(input logic [7:0] a);
    return par_sin(8'(a + QUARTER));
  endfunction

endpackage

// ===== design/sfn2d_setup.sv =====
module sfn2d_setup (
  input  logic                clk,
  input  sfn2d_pkg::pipe_ctl_t ctl,
  input  logic [15:0]         x_coord,
  input  logic [15:0]         y_coord,
  input  logic [7:0]          rotation_angle,
  output sfn2d_pkg::corner_t  corner_base,
  output sfn2d_pkg::corner_t  corner_mid,
  output sfn2d_pkg::corner_t  corner_top,
  output sfn2d_pkg::shared_t  shared
);
  import sfn2d_pkg::*;

  logic [10:0] su;
  logic [2:0]  bu;
  logic [2:0]  bv;
  logic        step_u;
  corner_t     base_nxt, mid_nxt, top_nxt;
  corner_t     base_r, mid_r, top_r;
  shared_t     shared_nxt, shared_r;

  // skew onto the simplex grid and pick the three corners
  always_comb begin
    su     = 11'(x_coord[10:0] + y_coord[11:1]);
    bu     = su[10:8];
    bv     = y_coord[10:8];
    step_u = su[7:0] > y_coord[7:0];

    base_nxt.cu = bu;
    base_nxt.cv = bv;
    mid_nxt.cu  = step_u ? 3'(bu + 3'd1) : bu;
    mid_nxt.cv  = step_u ? bv : 3'(bv + 3'd1);
    top_nxt.cu  = 3'(bu + 3'd1);
    top_nxt.cv  = 3'(bv + 3'd1);

    shared_nxt.lx  = x_coord[8:1];
    shared_nxt.ly  = y_coord[8:1];
    shared_nxt.rot = |rotation_angle;
    shared_nxt.sa  = par_sin(rotation_angle);
    shared_nxt.ca  = par_cos(rotation_angle);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (ctl.load[STG_SETUP]) begin
      base_r   <= base_nxt;
      mid_r    <= mid_nxt;
      top_r    <= top_nxt;
      shared_r <= shared_nxt;
    end
  end

  assign corner_base = base_r;
  assign corner_mid  = mid_r;
  assign corner_top  = top_r;
  assign shared      = shared_r;

endmodule

// ===== design/sfn2d_corner.sv =====
module sfn2d_corner (
  input  logic                 clk,
  input  sfn2d_pkg::pipe_ctl_t ctl,
  input  sfn2d_pkg::corner_t   corner,
  input  sfn2d_pkg::shared_t   shared,
  output logic signed [7:0]    term
);
  import sfn2d_pkg::*;

  // gradient stage
  logic [1:0]         pxm;
  logic [2:0]         h1, h2, hash;
  logic signed [7:0]  dx_nxt, dy_nxt, tx_nxt, ty_nxt;
  logic signed [15:0] ctx_nxt, sty_nxt, stx_nxt, cty_nxt, dxx_nxt, dyy_nxt;
  logic signed [7:0]  dx_b_r, dy_b_r, tx_r, ty_r;
  logic signed [15:0] ctx_r, sty_r, stx_r, cty_r, dxx_r, dyy_r;
  logic               rot_r;

  // rotation and radius stage
  logic signed [15:0] rx, ry;
  logic [15:0]        rad_sum;
  logic [7:0]         rad;
  logic signed [7:0]  gx_nxt, gy_nxt, gx_r, gy_r, dx_c_r, dy_c_r;
  logic [7:0]         mm1_nxt, mm1_r;

  // dot product and first falloff square
  logic signed [15:0] pgx_nxt, pgy_nxt, pgx_r, pgy_r;
  logic [15:0]        mm1_sq;
  logic [7:0]         mm2_r;

  // ramp and second falloff square
  logic signed [15:0] gsum;
  logic [15:0]        mm2_sq;
  logic signed [7:0]  g_r;
  logic [7:0]         mm3_r;

  // weighted term
  logic signed [16:0] gm;
  logic signed [7:0]  term_r;

  // offsets, hash, gradient pick and all products that depend on them
  always_comb begin
    pxm    = 2'({corner.cu[0], 1'b0} - corner.cv[1:0]);
    dx_nxt = $signed(8'(shared.lx - {pxm, 6'd0}));
    dy_nxt = $signed(8'(shared.ly - {corner.cv[0], 7'd0}));

    h1   = 3'(3'(HASH_A * corner.cu + HASH_B) * corner.cu);
    h2   = 3'(h1 + corner.cv);
    hash = 3'(3'(HASH_C * h2 + HASH_D) * h2);

    tx_nxt = hash[0] ? GRAD_LO : GRAD_HI;
    ty_nxt = hash[0] ? GRAD_HI : GRAD_LO;
    if (hash[1]) begin
      tx_nxt = 8'(-tx_nxt);
    end
    if (hash[2]) begin
      ty_nxt = 8'(-ty_nxt);
    end

    ctx_nxt = $signed(shared.ca) * tx_nxt;
    sty_nxt = $signed(shared.sa) * ty_nxt;
    stx_nxt = $signed(shared.sa) * tx_nxt;
    cty_nxt = $signed(shared.ca) * ty_nxt;
    dxx_nxt = dx_nxt * dx_nxt;
    dyy_nxt = dy_nxt * dy_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_GRAD]) begin
      dx_b_r <= dx_nxt;
      dy_b_r <= dy_nxt;
      tx_r   <= tx_nxt;
      ty_r   <= ty_nxt;
      rot_r  <= shared.rot;
      ctx_r  <= ctx_nxt;
      sty_r  <= sty_nxt;
      stx_r  <= stx_nxt;
      cty_r  <= cty_nxt;
      dxx_r  <= dxx_nxt;
      dyy_r  <= dyy_nxt;
    end
  end

  // rotated gradient, squared radius and falloff base
  always_comb begin
    rx      = (ctx_r >>> 7) - (sty_r >>> 7);
    ry      = (stx_r >>> 7) + (cty_r >>> 7);
    gx_nxt  = rot_r ? $signed(rx[7:0]) : tx_r;
    gy_nxt  = rot_r ? $signed(ry[7:0]) : ty_r;
    rad_sum = 16'((dxx_r >>> 7) + (dyy_r >>> 7));
    rad     = rad_sum[7:0];
    if (rad > FALLOFF_RADIUS) begin
      mm1_nxt = '0;
    end else begin
      mm1_nxt = 8'(FALLOFF_ONE - {rad[6:0], 1'b0} - {1'b0, rad[7:1]});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_ROT]) begin
      gx_r   <= gx_nxt;
      gy_r   <= gy_nxt;
      dx_c_r <= dx_b_r;
      dy_c_r <= dy_b_r;
      mm1_r  <= mm1_nxt;
    end
  end

  // ramp products and first falloff square
  always_comb begin
    pgx_nxt = gx_r * dx_c_r;
    pgy_nxt = gy_r * dy_c_r;
    mm1_sq  = mm1_r * mm1_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_DOT]) begin
      pgx_r <= pgx_nxt;
      pgy_r <= pgy_nxt;
      mm2_r <= mm1_sq[15:8];
    end
  end

  // ramp sum and second falloff square
  always_comb begin
    gsum   = (pgx_r >>> 7) + (pgy_r >>> 7);
    mm2_sq = mm2_r * mm2_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_FALL]) begin
      g_r   <= $signed(gsum[7:0]);
      mm3_r <= mm2_sq[15:8];
    end
  end

  // ramp weighted by falloff, floor shift by 6
  assign gm = g_r * $signed({1'b0, mm3_r});

  always_ff @(posedge clk) begin
    if (ctl.load[STG_TERM]) begin
      term_r <= $signed(gm[13:6]);
    end
  end

  assign term = term_r;

endmodule

// ===== design/sfn2d_sum.sv =====
module sfn2d_sum (
  input  logic                 clk,
  input  sfn2d_pkg::pipe_ctl_t ctl,
  input  logic signed [7:0]    term_base,
  input  logic signed [7:0]    term_mid,
  input  logic signed [7:0]    term_top,
  output logic signed [7:0]    noise_value
);
  import sfn2d_pkg::*;

  logic signed [9:0]  total;
  logic signed [17:0] scaled;
  logic signed [7:0]  noise_value_r;

  // add the three corners and scale by 136/128
  always_comb begin
    total  = $signed({{2{term_base[7]}}, term_base})
           + $signed({{2{term_mid[7]}}, term_mid})
           + $signed({{2{term_top[7]}}, term_top});
    scaled = total * OUT_GAIN;
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.load[STG_SUM]) begin
      noise_value_r <= $signed(scaled[14:7]);
    end
  end

  assign noise_value = noise_value_r;

endmodule

// ===== design/simplex_flow_noise_2d_8bit.sv =====
// 2-D simplex flow noise in 8-bit fixed point: each transfer on the in_ channel carries
// one 8.8 point and a rotation angle, and yields exactly one signed 1.7 noise value on the
// out_ channel, in order. The datapath is a seven-stage pipeline (corner setup, gradient
// pick, rotation and radius, ramp products, falloff squares, weighting, final sum) with the
// three simplex corners computed side by side, so a new point is taken every cycle when
// the output is not stalled, and each result leaves through the final sum register. Each
// stage carries a valid bit and loads only when it is empty or the stage after it moves, so
// back-pressure on out_ready fills empty stages first and in_ready stays high while any bubble
// remains. Nothing is kept between points; there are no configuration registers.
module simplex_flow_noise_2d_8bit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_x_coord,
  input  logic [15:0]       in_y_coord,
  input  logic [7:0]        in_rotation_angle,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] out_noise_value
);
  import sfn2d_pkg::*;

  logic [NUM_STAGES-1:0] valid_r, valid_nxt, valid_up;
  pipe_ctl_t             ctl;
  corner_t               corner_base, corner_mid, corner_top;
  shared_t               shared;
  logic signed [7:0]     term_base, term_mid, term_top;

  // load enables ripple back from the output; valid bits follow the data
  always_comb begin
    ctl.load[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ctl.load[i] = !valid_r[i] || ctl.load[i+1];
    end
    valid_up  = {valid_r[NUM_STAGES-2:0], in_valid};
    valid_nxt = (ctl.load & valid_up) | (~ctl.load & valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = ctl.load[STG_SETUP];
  assign out_valid = valid_r[STG_SUM];

  sfn2d_setup u_setup (
    .clk            (clk),
    .ctl            (ctl),
    .x_coord        (in_x_coord),
    .y_coord        (in_y_coord),
    .rotation_angle (in_rotation_angle),
    .corner_base    (corner_base),
    .corner_mid     (corner_mid),
    .corner_top     (corner_top),
    .shared         (shared)
  );

  sfn2d_corner u_corner_base (
    .clk    (clk),
    .ctl    (ctl),
    .corner (corner_base),
    .shared (shared),
    .term   (term_base)
  );

  sfn2d_corner u_corner_mid (
    .clk    (clk),
    .ctl    (ctl),
    .corner (corner_mid),
    .shared (shared),
    .term   (term_mid)
  );

  sfn2d_corner u_corner_top (
    .clk    (clk),
    .ctl    (ctl),
    .corner (corner_top),
    .shared (shared),
    .term   (term_top)
  );

  sfn2d_sum u_sum (
    .clk         (clk),
    .ctl         (ctl),
    .term_base   (term_base),
    .term_mid    (term_mid),
    .term_top    (term_top),
    .noise_value (out_noise_value)
  );

endmodule

// ===== design/sfn2d_checker.sv =====
module sfn2d_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] out_noise_value
);
  import sfn2d_pkg::*;

  localparam int CNT_W = $clog2(NUM_STAGES + 2);

  logic [CNT_W-1:0] inflight_r, inflight_nxt;

  // points taken but not yet delivered
  always_comb begin
    inflight_nxt = CNT_W'(inflight_r + CNT_W'(in_valid && in_ready)
                   - CNT_W'(out_valid && out_ready));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value))
    else $error("stalled result changed or dropped");

  // never more points in flight than pipeline stages
  a_inflight_max: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(NUM_STAGES))
    else $error("more points in flight than stages");

  // no result without a point behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != '0)
    else $error("result shown with nothing in flight");

  // a draining output lets the whole pipeline advance
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind simplex_flow_noise_2d_8bit sfn2d_checker u_sfn2d_checker (.*);
